// ===== sv/ihp_pkg.sv =====
// shared types, constants and codes of the implicit heat profile step unit
// no dependencies; compiled first
`default_nettype none
package ihp_pkg;

  localparam int MAX_POINTS = 256;
  localparam int IDX_W      = $clog2(MAX_POINTS);
  localparam int CNT_W      = 9;
  localparam int DIV_W      = 52;
  localparam int SUM_W      = 40;

  localparam logic [CNT_W-1:0] MIN_POINTS_C = 9'd20;
  localparam logic [CNT_W-1:0] MAX_POINTS_C = 9'd256;
  localparam logic [31:0]      LEVEL_MIN    = 32'd3277;
  localparam logic [31:0]      SIGN_FLIP    = 32'h8000_0000;
  localparam logic [DIV_W-1:0] ONE_Q32      = 52'h1_0000_0000;

  localparam logic [CNT_W-1:0] POINT_COUNT_RST = 9'd100;
  localparam logic [31:0]      GAIN_RST        = 32'd65536000;

  // op codes; the spare code behaves as compute only
  localparam logic [1:0] OP_COMPUTE = 2'd0;
  localparam logic [1:0] OP_COMMIT  = 2'd1;
  localparam logic [1:0] OP_FILL    = 2'd2;
  localparam logic [1:0] OP_SPARE   = 2'd3;

  // configuration register indexes
  localparam logic CFG_POINT_COUNT = 1'b0;
  localparam logic CFG_GAIN        = 1'b1;

  typedef enum logic [4:0] {
    ST_CLEAR, ST_IDLE, ST_FILL, ST_FLAT, ST_KMUL, ST_KDIV, ST_KWAIT, ST_INIT,
    ST_FRD, ST_FMA, ST_FMB, ST_FDIV, ST_FWA, ST_FWB, ST_BRD, ST_BMUL, ST_BADD,
    ST_MDIV, ST_MWAIT, ST_RESULT
  } state_t;

  typedef struct packed {
    logic             start;
    logic [DIV_W-1:0] hi;
    logic [31:0]      lo;
    logic [DIV_W-1:0] dvs;
  } div_req_t;

  typedef struct packed {
    logic        done;
    logic [31:0] quot;
  } div_rsp_t;

endpackage
`default_nettype wire

// ===== sv/ihp_in_if.sv =====
// input channel of the heat profile step unit
// depends on nothing but the handshake convention valid/ready
`default_nettype none
interface ihp_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  op;
  logic [31:0] time_step;
  logic signed [31:0] surface_temp;
  logic [31:0] liquid_level;
  modport source (output valid, op, time_step, surface_temp, liquid_level, input ready);
  modport sink   (input valid, op, time_step, surface_temp, liquid_level, output ready);
endinterface
`default_nettype wire

// ===== sv/ihp_out_if.sv =====
// result channel of the heat profile step unit
// depends on nothing but the handshake convention valid/ready
`default_nettype none
interface ihp_out_if;
  logic        valid;
  logic        ready;
  logic signed [31:0] mean_temp;
  logic        level_low;
  modport source (output valid, mean_temp, level_low, input ready);
  modport sink   (input valid, mean_temp, level_low, output ready);
endinterface
`default_nettype wire

// ===== sv/ihp_cfg_if.sv =====
// configuration write channel of the heat profile step unit
// depends on nothing but the handshake convention valid/ready
`default_nettype none
interface ihp_cfg_if;
  logic        valid;
  logic        ready;
  logic        index;
  logic [31:0] data;
  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface
`default_nettype wire

// ===== sv/ihp_div.sv =====
// serial restoring divider, one quotient bit per cycle, saturating to 32 bits
// depends on ihp_pkg
`default_nettype none
module ihp_div
  import ihp_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire div_req_t req,
  output div_rsp_t      rsp
);

  logic             busy_r, busy_nxt;
  logic             done_r, done_nxt;
  logic [5:0]       cnt_r, cnt_nxt;
  logic [DIV_W-1:0] rem_r, rem_nxt;
  logic [DIV_W-1:0] dvs_r, dvs_nxt;
  logic [31:0]      lo_r, lo_nxt;
  logic [31:0]      quo_r, quo_nxt;
  logic [DIV_W:0]   trial;
  logic [DIV_W:0]   diff;
  logic             ge;

  // one shift-subtract step
  assign trial = {rem_r, lo_r[31]};
  assign ge    = trial >= {1'b0, dvs_r};
  assign diff  = trial - {1'b0, dvs_r};

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    rem_nxt  = rem_r;
    dvs_nxt  = dvs_r;
    lo_nxt   = lo_r;
    quo_nxt  = quo_r;
    if (req.start) begin
      // quotient too large for 32 bits when the top part already reaches the divisor
      if (req.hi >= req.dvs) begin
        quo_nxt  = '1;
        done_nxt = 1'b1;
        busy_nxt = 1'b0;
      end else begin
        rem_nxt  = req.hi;
        lo_nxt   = req.lo;
        dvs_nxt  = req.dvs;
        cnt_nxt  = 6'd32;
        busy_nxt = 1'b1;
      end
    end else if (busy_r) begin
      rem_nxt = ge ? diff[DIV_W-1:0] : trial[DIV_W-1:0];
      quo_nxt = {quo_r[30:0], ge};
      lo_nxt  = {lo_r[30:0], 1'b0};
      cnt_nxt = cnt_r - 6'd1;
      if (cnt_r == 6'd1) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    rem_r <= rem_nxt;
    dvs_r <= dvs_nxt;
    lo_r  <= lo_nxt;
    quo_r <= quo_nxt;
  end

  assign rsp.done = done_r;
  assign rsp.quot = quo_r;

endmodule
`default_nettype wire

// ===== sv/implicit_heat_profile_step_unit.sv =====
// Implicit 1-D heat diffusion step over a stored profile (Thomas algorithm).
// Input channel in_chan carries op, time_step, surface_temp and liquid_level;
// result channel out_chan returns mean_temp and level_low, one item per input.
// cfg_chan writes point_count (index 0) and conduction_gain (index 1); it is
// always ready; the user must write it only while the unit is idle, and the
// unit does not enforce this. One item is worked on at a time; in_chan.ready
// is high only when idle. The serial divider (one quotient bit per cycle) runs
// twice per point of the forward sweep and once for its last point; one 32x32
// multiplier is shared too. After reset a clearing pass zeroes all entries of
// the profile memory before the first item is accepted. A finished result
// waits in the output register while the receiver stalls; the next item may be
// accepted meanwhile, but its result is held back until the register is free.
// depends on ihp_pkg, ihp_in_if, ihp_out_if, ihp_cfg_if, ihp_div
`default_nettype none
module implicit_heat_profile_step_unit
  import ihp_pkg::*;
(
  input  wire logic  clk,
  input  wire logic  rst_n,
  ihp_in_if.sink     in_chan,
  ihp_out_if.source  out_chan,
  ihp_cfg_if.sink    cfg_chan
);

  state_t state_r, state_nxt;

  logic [CNT_W-1:0] pc_r;
  logic [31:0]      gain_r;
  logic [IDX_W-1:0] idx_r, idx_nxt;
  logic [1:0]       op_r, op_nxt;
  logic [31:0]      t0_r, t0_nxt;
  logic [31:0]      dt_r, dt_nxt;
  logic [31:0]      lev_r, lev_nxt;
  logic [CNT_W-1:0] n_r, n_nxt;
  logic [31:0]      k_r, k_nxt;
  logic [31:0]      a_prev_r, a_prev_nxt;
  logic [31:0]      b_prev_r, b_prev_nxt;
  logic [63:0]      p_ka_r, p_ka_nxt;
  logic [DIV_W-1:0] d_r, d_nxt;
  logic [DIV_W-1:0] num_r, num_nxt;
  logic [31:0]      a_new_r, a_new_nxt;
  logic [31:0]      x_r, x_nxt;
  logic [SUM_W-1:0] sum_r, sum_nxt;
  logic [31:0]      res_mean_r, res_mean_nxt;
  logic             res_low_r, res_low_nxt;
  logic             out_valid_r;
  logic [31:0]      out_mean_r;
  logic             out_low_r;
  logic             out_load;

  // shared multiplier
  logic [31:0] mul_a, mul_b;
  logic [63:0] prod_r;

  // memories
  logic [31:0]      prof_mem [MAX_POINTS];
  logic [63:0]      ab_mem   [MAX_POINTS];
  logic             prof_we, prof_re, ab_we, ab_re;
  logic [IDX_W-1:0] prof_waddr, prof_raddr, ab_waddr, ab_raddr;
  logic [31:0]      prof_wdata, prof_q_r;
  logic [63:0]      ab_wdata, ab_q_r;

  div_req_t div_req;
  div_rsp_t div_rsp;

  logic             in_fire;
  logic [CNT_W-1:0] n_clamp;
  logic             is_last;
  logic             commit;
  logic [32:0]      back_sum;
  logic [31:0]      back_x;

  ihp_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (div_req),
    .rsp   (div_rsp)
  );

  assign in_chan.ready  = (state_r == ST_IDLE);
  assign in_fire        = in_chan.valid && in_chan.ready;
  assign cfg_chan.ready = 1'b1;

  assign out_chan.valid     = out_valid_r;
  assign out_chan.mean_temp = out_mean_r;
  assign out_chan.level_low = out_low_r;

  // point count in use, clamped to the supported range
  always_comb begin
    n_clamp = pc_r;
    if (pc_r < MIN_POINTS_C) n_clamp = MIN_POINTS_C;
    if (pc_r > MAX_POINTS_C) n_clamp = MAX_POINTS_C;
  end

  assign is_last  = ({1'b0, idx_r} == n_r - 9'd1);
  assign commit   = (op_r == OP_COMMIT);
  assign back_sum = {1'b0, prod_r[63:32]} + {1'b0, ab_q_r[31:0]};
  assign back_x   = back_sum[32] ? 32'hFFFF_FFFF : back_sum[31:0];

  // sequencer: next state, datapath and memory controls
  always_comb begin
    state_nxt    = state_r;
    idx_nxt      = idx_r;
    op_nxt       = op_r;
    t0_nxt       = t0_r;
    dt_nxt       = dt_r;
    lev_nxt      = lev_r;
    n_nxt        = n_r;
    k_nxt        = k_r;
    a_prev_nxt   = a_prev_r;
    b_prev_nxt   = b_prev_r;
    p_ka_nxt     = p_ka_r;
    d_nxt        = d_r;
    num_nxt      = num_r;
    a_new_nxt    = a_new_r;
    x_nxt        = x_r;
    sum_nxt      = sum_r;
    res_mean_nxt = res_mean_r;
    res_low_nxt  = res_low_r;
    out_load     = 1'b0;
    mul_a        = k_r;
    mul_b        = a_prev_r;
    prof_we      = 1'b0;
    prof_waddr   = idx_r;
    prof_wdata   = t0_r;
    prof_re      = 1'b0;
    prof_raddr   = idx_r;
    ab_we        = 1'b0;
    ab_waddr     = idx_r;
    ab_wdata     = {a_new_r, div_rsp.quot};
    ab_re        = 1'b0;
    ab_raddr     = idx_r - 8'd1;
    div_req      = '0;

    unique case (state_r)
      ST_CLEAR: begin
        prof_we    = 1'b1;
        prof_wdata = '0;
        idx_nxt    = idx_r + 8'd1;
        if (idx_r == IDX_W'(MAX_POINTS - 1)) state_nxt = ST_IDLE;
      end
      ST_IDLE: begin
        if (in_fire) begin
          op_nxt  = in_chan.op;
          t0_nxt  = in_chan.surface_temp;
          dt_nxt  = in_chan.time_step;
          lev_nxt = in_chan.liquid_level;
          n_nxt   = n_clamp;
          idx_nxt = '0;
          if (in_chan.op == OP_FILL) state_nxt = ST_FILL;
          else if (in_chan.liquid_level < LEVEL_MIN) state_nxt = ST_FLAT;
          else state_nxt = ST_KMUL;
        end
      end
      ST_FILL: begin
        prof_we = 1'b1;
        idx_nxt = idx_r + 8'd1;
        if (idx_r == IDX_W'(MAX_POINTS - 1)) begin
          res_mean_nxt = t0_r;
          res_low_nxt  = 1'b0;
          state_nxt    = ST_RESULT;
        end
      end
      ST_FLAT: begin
        prof_we = commit;
        idx_nxt = idx_r + 8'd1;
        if (is_last) begin
          res_mean_nxt = t0_r;
          res_low_nxt  = 1'b1;
          state_nxt    = ST_RESULT;
        end
      end
      ST_KMUL: begin
        mul_a     = gain_r;
        mul_b     = dt_r;
        state_nxt = ST_KDIV;
      end
      ST_KDIV: begin
        div_req.start = 1'b1;
        div_req.hi    = {20'd0, prod_r[63:32]};
        div_req.lo    = prod_r[31:0];
        div_req.dvs   = {20'd0, lev_r};
        state_nxt     = ST_KWAIT;
      end
      ST_KWAIT: begin
        if (div_rsp.done) begin
          k_nxt     = div_rsp.quot;
          state_nxt = ST_INIT;
        end
      end
      ST_INIT: begin
        // first point is pinned to the surface temperature
        ab_we      = 1'b1;
        ab_waddr   = '0;
        ab_wdata   = {32'd0, t0_r ^ SIGN_FLIP};
        a_prev_nxt = '0;
        b_prev_nxt = t0_r ^ SIGN_FLIP;
        idx_nxt    = 8'd1;
        state_nxt  = ST_FRD;
      end
      ST_FRD: begin
        prof_re   = 1'b1;
        mul_a     = k_r;
        mul_b     = a_prev_r;
        state_nxt = ST_FMA;
      end
      ST_FMA: begin
        p_ka_nxt  = prod_r;
        mul_a     = k_r;
        mul_b     = b_prev_r;
        state_nxt = ST_FMB;
      end
      ST_FMB: begin
        // diagonal term; the insulated bottom uses one k less
        if (is_last) d_nxt = ONE_Q32 + {4'd0, k_r, 16'd0} - {4'd0, p_ka_r[63:16]};
        else         d_nxt = ONE_Q32 + {3'd0, k_r, 17'd0} - {4'd0, p_ka_r[63:16]};
        num_nxt   = {20'd0, prof_q_r ^ SIGN_FLIP} + {4'd0, prod_r[63:16]};
        state_nxt = ST_FDIV;
      end
      ST_FDIV: begin
        div_req.start = 1'b1;
        div_req.dvs   = d_r;
        div_req.lo    = '0;
        if (is_last) begin
          div_req.hi = num_r;
          state_nxt  = ST_FWB;
        end else begin
          div_req.hi = {4'd0, k_r, 16'd0};
          state_nxt  = ST_FWA;
        end
      end
      ST_FWA: begin
        if (div_rsp.done) begin
          a_new_nxt     = div_rsp.quot;
          div_req.start = 1'b1;
          div_req.hi    = num_r;
          div_req.lo    = '0;
          div_req.dvs   = d_r;
          state_nxt     = ST_FWB;
        end
      end
      ST_FWB: begin
        if (div_rsp.done) begin
          if (is_last) begin
            x_nxt      = div_rsp.quot;
            sum_nxt    = {8'd0, div_rsp.quot};
            prof_we    = commit;
            prof_wdata = div_rsp.quot ^ SIGN_FLIP;
            state_nxt  = ST_BRD;
          end else begin
            ab_we      = 1'b1;
            a_prev_nxt = a_new_r;
            b_prev_nxt = div_rsp.quot;
            idx_nxt    = idx_r + 8'd1;
            state_nxt  = ST_FRD;
          end
        end
      end
      ST_BRD: begin
        ab_re     = 1'b1;
        state_nxt = ST_BMUL;
      end
      ST_BMUL: begin
        mul_a     = ab_q_r[63:32];
        mul_b     = x_r;
        state_nxt = ST_BADD;
      end
      ST_BADD: begin
        // back substitution of one point
        x_nxt      = back_x;
        sum_nxt    = sum_r + {8'd0, back_x};
        prof_we    = commit;
        prof_waddr = idx_r - 8'd1;
        prof_wdata = back_x ^ SIGN_FLIP;
        idx_nxt    = idx_r - 8'd1;
        if (idx_r == 8'd1) state_nxt = ST_MDIV;
        else state_nxt = ST_BRD;
      end
      ST_MDIV: begin
        div_req.start = 1'b1;
        div_req.hi    = {44'd0, sum_r[39:32]};
        div_req.lo    = sum_r[31:0];
        div_req.dvs   = {43'd0, n_r};
        state_nxt     = ST_MWAIT;
      end
      ST_MWAIT: begin
        if (div_rsp.done) begin
          res_mean_nxt = div_rsp.quot ^ SIGN_FLIP;
          res_low_nxt  = 1'b0;
          state_nxt    = ST_RESULT;
        end
      end
      ST_RESULT: begin
        if (!out_valid_r || out_chan.ready) begin
          out_load  = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // state and control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      idx_r       <= '0;
      out_valid_r <= 1'b0;
      pc_r        <= POINT_COUNT_RST;
      gain_r      <= GAIN_RST;
    end else begin
      state_r <= state_nxt;
      idx_r   <= idx_nxt;
      if (out_valid_r && out_chan.ready) out_valid_r <= 1'b0;
      if (out_load) out_valid_r <= 1'b1;
      if (cfg_chan.valid && cfg_chan.ready) begin
        unique case (cfg_chan.index)
          CFG_POINT_COUNT: pc_r   <= cfg_chan.data[CNT_W-1:0];
          CFG_GAIN:        gain_r <= cfg_chan.data;
          default: ;
        endcase
      end
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    op_r       <= op_nxt;
    t0_r       <= t0_nxt;
    dt_r       <= dt_nxt;
    lev_r      <= lev_nxt;
    n_r        <= n_nxt;
    k_r        <= k_nxt;
    a_prev_r   <= a_prev_nxt;
    b_prev_r   <= b_prev_nxt;
    p_ka_r     <= p_ka_nxt;
    d_r        <= d_nxt;
    num_r      <= num_nxt;
    a_new_r    <= a_new_nxt;
    x_r        <= x_nxt;
    sum_r      <= sum_nxt;
    res_mean_r <= res_mean_nxt;
    res_low_r  <= res_low_nxt;
    prod_r     <= mul_a * mul_b;
    if (out_load) begin
      out_mean_r <= res_mean_r;
      out_low_r  <= res_low_r;
    end
  end

  // temperature profile memory
  always_ff @(posedge clk) begin
    if (prof_we) prof_mem[prof_waddr] <= prof_wdata;
    if (prof_re) prof_q_r <= prof_mem[prof_raddr];
  end

  // sweep coefficient memory, A in the upper half and B in the lower half
  always_ff @(posedge clk) begin
    if (ab_we) ab_mem[ab_waddr] <= ab_wdata;
    if (ab_re) ab_q_r <= ab_mem[ab_raddr];
  end

endmodule
`default_nettype wire
